/* hw/rtl/mts_pkg.sv */
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes for the multi-timer scheduler: request opcodes,
// response status codes, the response record and the sequencer states.
// ----------------------------------------------------------------------------
package mts_pkg;

   // fixed field widths of the request and response channels
   localparam int OP_W       = 3;
   localparam int SLOT_ID_W  = 4;
   localparam int TIME_IN_W  = 32;
   localparam int TIME_OUT_W = 32;
   localparam int TAG_W      = 16;
   localparam int STATUS_W   = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 3'd0,
      OP_CANCEL  = 3'd1,
      OP_PROCESS = 3'd2,
      OP_NEXT    = 3'd3,
      OP_INFO    = 3'd4
   } op_type;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_PENDING  = 3'd4;

   typedef struct packed {
      logic [SLOT_ID_W-1:0]  slot_id;
      logic [STATUS_W-1:0]   status;
      logic [TIME_OUT_W-1:0] time_out;
      logic [TIME_OUT_W-1:0] interval_out;
      logic [TAG_W-1:0]      tag_out;
      logic                  fired;
      logic                  last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_DECIDE,
      S_INFO
   } state_type;

endpackage

/* hw/rtl/mts_ram.sv */
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* hw/rtl/multi_timer_scheduler_top.sv */
// ----------------------------------------------------------------------------
// multi_timer_scheduler_top
// Timer slot table with add, cancel, earliest-deadline process and queries,
// run by a small sequencer around one slot RAM and one scan comparator.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   -----------------------------------------
//   request   req_valid / req_ready   op, slot, time_value, reload_interval,
//                                     user_tag
//   response  rsp_valid / rsp_ready   slot_id, status, time_out, interval_out,
//                                     tag_out, fired, last
//
// Cancel, unknown ops and a missed slot info answer from dispatch; a hit slot
// info reads its slot first. Add and next expiry make one scan of the slot RAM at
// one entry a cycle; process scans once and rescans after each firing.
// Reset clears the active bits at once; a stored entry is only used while its
// slot is active, so the slot RAM needs no clearing pass.
// A stalled response holds the sequencer; req_ready is high only while idle.
// ----------------------------------------------------------------------------
module multi_timer_scheduler_top #(
   parameter int SLOTS     = 16,
   parameter int TIME_BITS = 32,
   parameter int MAX_FIRES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mts_pkg::OP_W-1:0]          req_op,
   input  logic [mts_pkg::SLOT_ID_W-1:0]     req_slot,
   input  logic [mts_pkg::TIME_IN_W-1:0]     req_time_value,
   input  logic [mts_pkg::TIME_IN_W-1:0]     req_reload_interval,
   input  logic [mts_pkg::TAG_W-1:0]         req_user_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mts_pkg::SLOT_ID_W-1:0]     rsp_slot_id,
   output logic [mts_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mts_pkg::TIME_OUT_W-1:0]    rsp_time_out,
   output logic [mts_pkg::TIME_OUT_W-1:0]    rsp_interval_out,
   output logic [mts_pkg::TAG_W-1:0]         rsp_tag_out,
   output logic                              rsp_fired,
   output logic                              rsp_last
);

   import mts_pkg::*;

   localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int FCNT_W = $clog2(MAX_FIRES + 1);
   localparam int WORD_W = 2 * TIME_BITS + TAG_W;

   localparam logic [CNT_W-1:0]  SLOT_COUNT = CNT_W'(SLOTS);
   localparam logic [FCNT_W-1:0] FIRE_LIMIT = FCNT_W'(MAX_FIRES);

   // sequencer and request registers
   state_type               state_ff, state_in;
   logic [OP_W-1:0]         op_ff;
   logic [SLOT_ID_W-1:0]    slot_ff;
   logic [TIME_BITS-1:0]    tv_ff;
   logic [TIME_BITS-1:0]    iv_ff;
   logic [TAG_W-1:0]        tag_ff;

   // slot state
   logic [SLOTS-1:0]        active_ff, active_in;

   // scan
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [SIDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                    best_vld_ff, best_vld_in;
   logic [SIDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [TIME_BITS-1:0]    best_dl_ff, best_dl_in;
   logic [TIME_BITS-1:0]    best_per_ff, best_per_in;
   logic [TAG_W-1:0]        best_tag_ff, best_tag_in;

   // firing held until the next scan tells whether it is the last one
   logic                    pend_vld_ff, pend_vld_in;
   rsp_type                 pend_ff, pend_in;
   logic [FCNT_W-1:0]       fire_cnt_ff, fire_cnt_in;

   // response register
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   logic                    emit;
   rsp_type                 emit_data;
   logic                    out_free;

   // slot RAM: {deadline, period, tag}
   logic                    ram_we;
   logic [SIDX_W-1:0]       ram_waddr;
   logic [WORD_W-1:0]       ram_wdata;
   logic [SIDX_W-1:0]       ram_raddr;
   logic [WORD_W-1:0]       ram_rdata;
   logic [TIME_BITS-1:0]    rd_dl;
   logic [TIME_BITS-1:0]    rd_per;
   logic [TAG_W-1:0]        rd_tag;

   // datapath helpers
   logic [SIDX_W-1:0]       slot_idx;
   logic                    slot_hit;
   logic                    take;
   logic                    more;
   logic                    retire;
   logic [TIME_BITS:0]      reload_sum;
   logic [TIME_BITS-1:0]    remain;
   logic                    start_scan;
   logic                    do_fire;

   mts_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_dl  = ram_rdata[WORD_W-1 -: TIME_BITS];
   assign rd_per = ram_rdata[TAG_W +: TIME_BITS];
   assign rd_tag = ram_rdata[TAG_W-1:0];

   // target slot for cancel and info: in range and active
   assign slot_idx = SIDX_W'(slot_ff);
   assign slot_hit = (32'(slot_ff) < 32'(SLOTS)) && active_ff[slot_idx];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // scan comparator: decide whether the entry just read replaces the best
   always_comb begin
      case (op_ff)
         OP_ADD: begin
            // first free slot wins
            take = !active_ff[cmp_idx_ff] && !best_vld_ff;
         end
         OP_PROCESS: begin
            take = active_ff[cmp_idx_ff] && (rd_dl <= tv_ff)
                   && (!best_vld_ff || (rd_dl < best_dl_ff));
         end
         default: begin
            take = active_ff[cmp_idx_ff] && (!best_vld_ff || (rd_dl < best_dl_ff));
         end
      endcase
   end

   // a zero period or a reload past the top of the time range retires the slot
   assign reload_sum = {1'b0, best_dl_ff} + {1'b0, best_per_ff};
   assign retire     = (best_per_ff == '0) || reload_sum[TIME_BITS];
   assign remain     = (best_dl_ff >= tv_ff) ? (best_dl_ff - tv_ff) : '0;
   assign more       = best_vld_ff && (fire_cnt_ff != FIRE_LIMIT);

   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      cnt_in      = cnt_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      best_vld_in = best_vld_ff;
      best_idx_in = best_idx_ff;
      best_dl_in  = best_dl_ff;
      best_per_in = best_per_ff;
      best_tag_in = best_tag_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      fire_cnt_in = fire_cnt_ff;
      emit        = 1'b0;
      emit_data   = '0;
      ram_we      = 1'b0;
      ram_waddr   = best_idx_ff;
      ram_wdata   = {tv_ff, iv_ff, tag_ff};
      ram_raddr   = slot_idx;
      start_scan  = 1'b0;
      do_fire     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            case (op_ff)
               OP_ADD, OP_NEXT: begin
                  start_scan = 1'b1;
               end
               OP_PROCESS: begin
                  start_scan  = 1'b1;
                  fire_cnt_in = '0;
                  pend_vld_in = 1'b0;
               end
               OP_CANCEL: begin
                  if (out_free) begin
                     emit              = 1'b1;
                     emit_data.slot_id = slot_ff;
                     emit_data.status  = slot_hit ? ST_OK : ST_INACTIVE;
                     emit_data.last    = 1'b1;
                     if (slot_hit) begin
                        active_in[slot_idx] = 1'b0;
                     end
                     state_in = S_IDLE;
                  end
               end
               OP_INFO: begin
                  if (slot_hit) begin
                     state_in = S_INFO;
                  end else if (out_free) begin
                     emit              = 1'b1;
                     emit_data.slot_id = slot_ff;
                     emit_data.status  = ST_INACTIVE;
                     emit_data.last    = 1'b1;
                     state_in          = S_IDLE;
                  end
               end
               default: begin
                  // unknown op: one empty closing response
                  if (out_free) begin
                     emit           = 1'b1;
                     emit_data.last = 1'b1;
                     state_in       = S_IDLE;
                  end
               end
            endcase
         end

         S_INFO: begin
            // read address holds on the target slot, so the data stays put
            if (out_free) begin
               emit                   = 1'b1;
               emit_data.slot_id      = slot_ff;
               emit_data.status       = ST_OK;
               emit_data.time_out     = TIME_OUT_W'(rd_dl);
               emit_data.interval_out = TIME_OUT_W'(rd_per);
               emit_data.tag_out      = rd_tag;
               emit_data.last         = 1'b1;
               state_in               = S_IDLE;
            end
         end

         S_SCAN: begin
            // issue one read a cycle, compare the entry read the cycle before
            if (cnt_ff < SLOT_COUNT) begin
               ram_raddr  = cnt_ff[SIDX_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = cnt_ff[SIDX_W-1:0];
            end else begin
               cmp_vld_in = 1'b0;
               if (!cmp_vld_ff) begin
                  state_in = S_DECIDE;
               end
            end
            if (cmp_vld_ff && take) begin
               best_vld_in = 1'b1;
               best_idx_in = cmp_idx_ff;
               best_dl_in  = rd_dl;
               best_per_in = rd_per;
               best_tag_in = rd_tag;
            end
         end

         S_DECIDE: begin
            case (op_ff)
               OP_ADD: begin
                  if (out_free) begin
                     emit           = 1'b1;
                     emit_data.last = 1'b1;
                     if (best_vld_ff) begin
                        ram_we                 = 1'b1;
                        active_in[best_idx_ff] = 1'b1;
                        emit_data.slot_id      = SLOT_ID_W'(best_idx_ff);
                        emit_data.status       = ST_OK;
                     end else begin
                        emit_data.status = ST_FULL;
                     end
                     state_in = S_IDLE;
                  end
               end
               OP_PROCESS: begin
                  if (pend_vld_ff) begin
                     // release the held firing once the rescan is in
                     if (out_free) begin
                        emit           = 1'b1;
                        emit_data      = pend_ff;
                        emit_data.last = !more;
                        if (best_vld_ff && !more) begin
                           emit_data.status = ST_PENDING;
                        end
                        if (more) begin
                           do_fire = 1'b1;
                        end else begin
                           pend_vld_in = 1'b0;
                           state_in    = S_IDLE;
                        end
                     end
                  end else if (best_vld_ff) begin
                     do_fire = 1'b1;
                  end else if (out_free) begin
                     emit             = 1'b1;
                     emit_data.status = ST_NONE;
                     emit_data.last   = 1'b1;
                     state_in         = S_IDLE;
                  end
               end
               default: begin
                  // next expiry
                  if (out_free) begin
                     emit           = 1'b1;
                     emit_data.last = 1'b1;
                     if (best_vld_ff) begin
                        emit_data.slot_id      = SLOT_ID_W'(best_idx_ff);
                        emit_data.status       = ST_OK;
                        emit_data.time_out     = TIME_OUT_W'(remain);
                        emit_data.interval_out = TIME_OUT_W'(best_per_ff);
                        emit_data.tag_out      = best_tag_ff;
                     end else begin
                        emit_data.status = ST_NONE;
                     end
                     state_in = S_IDLE;
                  end
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // fire the best due slot: hold its result, reload or free it, rescan
      if (do_fire) begin
         pend_vld_in          = 1'b1;
         pend_in              = '0;
         pend_in.slot_id      = SLOT_ID_W'(best_idx_ff);
         pend_in.status       = ST_OK;
         pend_in.time_out     = TIME_OUT_W'(best_dl_ff);
         pend_in.interval_out = TIME_OUT_W'(best_per_ff);
         pend_in.tag_out      = best_tag_ff;
         pend_in.fired        = 1'b1;
         fire_cnt_in          = fire_cnt_ff + 1'b1;
         if (retire) begin
            active_in[best_idx_ff] = 1'b0;
         end else begin
            ram_we    = 1'b1;
            ram_wdata = {reload_sum[TIME_BITS-1:0], best_per_ff, best_tag_ff};
         end
         start_scan = 1'b1;
      end

      if (start_scan) begin
         cnt_in      = '0;
         cmp_vld_in  = 1'b0;
         best_vld_in = 1'b0;
         state_in    = S_SCAN;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         best_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         fire_cnt_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         active_ff   <= active_in;
         cmp_vld_ff  <= cmp_vld_in;
         best_vld_ff <= best_vld_in;
         pend_vld_ff <= pend_vld_in;
         fire_cnt_ff <= fire_cnt_in;
         cnt_ff      <= cnt_in;
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_op;
         slot_ff <= req_slot;
         tv_ff   <= TIME_BITS'(req_time_value);
         iv_ff   <= TIME_BITS'(req_reload_interval);
         tag_ff  <= req_user_tag;
      end
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_dl_ff  <= best_dl_in;
      best_per_ff <= best_per_in;
      best_tag_ff <= best_tag_in;
      pend_ff     <= pend_in;
      if (out_free && emit) begin
         rsp_ff <= emit_data;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_id      = rsp_ff.slot_id;
   assign rsp_status       = rsp_ff.status;
   assign rsp_time_out     = rsp_ff.time_out;
   assign rsp_interval_out = rsp_ff.interval_out;
   assign rsp_tag_out      = rsp_ff.tag_out;
   assign rsp_fired        = rsp_ff.fired;
   assign rsp_last         = rsp_ff.last;

   // firing count never runs past the result limit
   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= FIRE_LIMIT)
      else $error("firing count past limit");

   // a held firing keeps new requests out
   a_pend_blocks: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> !req_ready)
      else $error("request taken while a firing is held");

   // only the closing response of a process call may flag pending firings
   a_pending_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_PENDING) |-> (rsp_last && rsp_fired))
      else $error("pending status on a response that does not close");

   // an accepted request keeps the sequencer busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after accept");

endmodule

/* verif/multi_timer_scheduler_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_scheduler_checker
// Watches the request and response channels of the timer scheduler, keeps a
// shadow slot table, predicts the responses of each accepted request and
// compares every accepted response with the oldest one still owed.
// ----------------------------------------------------------------------------
module multi_timer_scheduler_checker #(
   parameter int SLOTS     = 16,
   parameter int MAX_FIRES = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [mts_pkg::OP_W-1:0]       req_op,
   input  logic [mts_pkg::SLOT_ID_W-1:0]  req_slot,
   input  logic [mts_pkg::TIME_IN_W-1:0]  req_time_value,
   input  logic [mts_pkg::TIME_IN_W-1:0]  req_reload_interval,
   input  logic [mts_pkg::TAG_W-1:0]      req_user_tag,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [mts_pkg::SLOT_ID_W-1:0]  rsp_slot_id,
   input  logic [mts_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [mts_pkg::TIME_OUT_W-1:0] rsp_time_out,
   input  logic [mts_pkg::TIME_OUT_W-1:0] rsp_interval_out,
   input  logic [mts_pkg::TAG_W-1:0]      rsp_tag_out,
   input  logic                           rsp_fired,
   input  logic                           rsp_last,
   output int                             fail_count,
   output int                             responses_owed
);

   import mts_pkg::*;

   // shadow slot table
   bit [TIME_IN_W-1:0] deadline_q [SLOTS];
   bit [TIME_IN_W-1:0] period_q [SLOTS];
   bit [TAG_W-1:0]     tag_q [SLOTS];
   bit                 active_q [SLOTS];

   rsp_type pending_responses [$];

   // earliest active slot, optionally only the ones due at now; -1 if none
   function automatic int earliest_slot(input bit only_due, input bit [TIME_IN_W-1:0] now);
      int best;
      best = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (active_q[i] && !(only_due && deadline_q[i] > now)) begin
            if (best < 0 || deadline_q[i] < deadline_q[best]) best = i;
         end
      end
      return best;
   endfunction

   function automatic rsp_type make_rsp(input int sid, input logic [STATUS_W-1:0] st,
                                        input bit [TIME_OUT_W-1:0] t,
                                        input bit [TIME_OUT_W-1:0] iv,
                                        input bit [TAG_W-1:0] tg, input bit fi);
      rsp_type r;
      r.slot_id      = SLOT_ID_W'(sid);
      r.status       = st;
      r.time_out     = t;
      r.interval_out = iv;
      r.tag_out      = tg;
      r.fired        = fi;
      r.last         = 1'b0;
      return r;
   endfunction

   task automatic apply_request(input logic [OP_W-1:0] op, input logic [SLOT_ID_W-1:0] sl,
                                input bit [TIME_IN_W-1:0] tv, input bit [TIME_IN_W-1:0] iv,
                                input bit [TAG_W-1:0] ut);
      rsp_type            batch [$];
      rsp_type            r;
      int                 s;
      bit [TIME_IN_W:0]   sum;
      bit [TIME_IN_W-1:0] rem;
      case (op)
         OP_ADD: begin
            s = -1;
            for (int i = SLOTS - 1; i >= 0; i--) if (!active_q[i]) s = i;
            if (s < 0) begin
               batch.push_back(make_rsp(0, ST_FULL, 0, 0, 0, 1'b0));
            end else begin
               deadline_q[s] = tv;
               period_q[s]   = iv;
               tag_q[s]      = ut;
               active_q[s]   = 1'b1;
               batch.push_back(make_rsp(s, ST_OK, 0, 0, 0, 1'b0));
            end
         end
         OP_CANCEL: begin
            if (int'(sl) < SLOTS && active_q[sl]) begin
               active_q[sl] = 1'b0;
               batch.push_back(make_rsp(int'(sl), ST_OK, 0, 0, 0, 1'b0));
            end else begin
               batch.push_back(make_rsp(int'(sl), ST_INACTIVE, 0, 0, 0, 1'b0));
            end
         end
         OP_PROCESS: begin
            while (batch.size() < MAX_FIRES) begin
               s = earliest_slot(1'b1, tv);
               if (s < 0) break;
               batch.push_back(make_rsp(s, ST_OK, deadline_q[s], period_q[s], tag_q[s], 1'b1));
               // retire one-shots and any reload that would pass the top of time
               sum = {1'b0, deadline_q[s]} + {1'b0, period_q[s]};
               if (period_q[s] == 0 || sum[TIME_IN_W]) active_q[s] = 1'b0;
               else deadline_q[s] = sum[TIME_IN_W-1:0];
            end
            if (batch.size() == 0) begin
               batch.push_back(make_rsp(0, ST_NONE, 0, 0, 0, 1'b0));
            end else if (earliest_slot(1'b1, tv) >= 0) begin
               r = batch.pop_back();
               r.status = ST_PENDING;
               batch.push_back(r);
            end
         end
         OP_NEXT: begin
            s = earliest_slot(1'b0, 0);
            if (s < 0) begin
               batch.push_back(make_rsp(0, ST_NONE, 0, 0, 0, 1'b0));
            end else begin
               rem = (deadline_q[s] >= tv) ? deadline_q[s] - tv : 0;
               batch.push_back(make_rsp(s, ST_OK, rem, period_q[s], tag_q[s], 1'b0));
            end
         end
         OP_INFO: begin
            if (int'(sl) < SLOTS && active_q[sl])
               batch.push_back(make_rsp(int'(sl), ST_OK, deadline_q[sl], period_q[sl],
                                        tag_q[sl], 1'b0));
            else
               batch.push_back(make_rsp(int'(sl), ST_INACTIVE, 0, 0, 0, 1'b0));
         end
         default: begin
            batch.push_back(make_rsp(0, ST_OK, 0, 0, 0, 1'b0));
         end
      endcase
      r = batch.pop_back();
      r.last = 1'b1;
      batch.push_back(r);
      foreach (batch[i]) pending_responses.push_back(batch[i]);
   endtask

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_response();
      rsp_type want;
      if (pending_responses.size() == 0) begin
         $error("response with none owed: slot_id %0d status %0d", rsp_slot_id, rsp_status);
         fail_count++;
      end else begin
         want = pending_responses.pop_front();
         compare_field("slot_id", 32'(want.slot_id), 32'(rsp_slot_id));
         compare_field("status", 32'(want.status), 32'(rsp_status));
         compare_field("time_out", want.time_out, rsp_time_out);
         compare_field("interval_out", want.interval_out, rsp_interval_out);
         compare_field("tag_out", 32'(want.tag_out), 32'(rsp_tag_out));
         compare_field("fired", 32'(want.fired), 32'(rsp_fired));
         compare_field("last", 32'(want.last), 32'(rsp_last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (active_q[i]) active_q[i] = 1'b0;
         pending_responses.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_response();
         if (req_valid && req_ready)
            apply_request(req_op, req_slot, req_time_value, req_reload_interval, req_user_tag);
      end
      responses_owed = pending_responses.size();
   end

endmodule

/* verif/multi_timer_scheduler_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_scheduler_top_tb
// Drives the timer scheduler with a directed run over its corner cases, then
// random add, cancel, process and query requests around a moving clock, with
// random stalls on both channels; a checker beside the block predicts and
// compares every response.
// ----------------------------------------------------------------------------
module multi_timer_scheduler_top_tb;
   import mts_pkg::*;

   localparam int SLOTS        = 16;
   localparam int MAX_FIRES    = 64;
   localparam int RANDOM_ITEMS = 90;
   localparam int QUIET_ITEMS  = 20;    // tail of the run with no idling
   localparam int HOLD_AT      = 40;    // request index that starts the long hold
   localparam int DRAIN_AT     = 60;    // request index that waits for every response
   localparam int LONG_HOLD    = 300;   // cycles the receiver holds off
   localparam int DRAIN_CYCLES = 2 * (SLOTS + 4);
   localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake before giving up

   // top opcode value; everything above OP_INFO is unknown to the block
   localparam logic [OP_W-1:0] OP_TOP = '1;

   logic                  clock;
   logic                  reset               = 1'b1;
   logic                  req_valid           = 1'b0;
   logic                  req_ready;
   logic [OP_W-1:0]       req_op              = '0;
   logic [SLOT_ID_W-1:0]  req_slot            = '0;
   logic [TIME_IN_W-1:0]  req_time_value      = '0;
   logic [TIME_IN_W-1:0]  req_reload_interval = '0;
   logic [TAG_W-1:0]      req_user_tag        = '0;
   logic                  rsp_valid;
   logic                  rsp_ready           = 1'b0;
   logic [SLOT_ID_W-1:0]  rsp_slot_id;
   logic [STATUS_W-1:0]   rsp_status;
   logic [TIME_OUT_W-1:0] rsp_time_out;
   logic [TIME_OUT_W-1:0] rsp_interval_out;
   logic [TAG_W-1:0]      rsp_tag_out;
   logic                  rsp_fired;
   logic                  rsp_last;

   int fail_count;
   int responses_owed;
   bit long_hold = 1'b0;   // ask the receiver for one long stall
   bit no_idle   = 1'b0;   // final stretch: both sides stay busy

   multi_timer_scheduler_top #(
      .SLOTS     (SLOTS),
      .MAX_FIRES (MAX_FIRES)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_slot            (req_slot),
      .req_time_value      (req_time_value),
      .req_reload_interval (req_reload_interval),
      .req_user_tag        (req_user_tag),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_slot_id         (rsp_slot_id),
      .rsp_status          (rsp_status),
      .rsp_time_out        (rsp_time_out),
      .rsp_interval_out    (rsp_interval_out),
      .rsp_tag_out         (rsp_tag_out),
      .rsp_fired           (rsp_fired),
      .rsp_last            (rsp_last)
   );

   multi_timer_scheduler_checker #(
      .SLOTS     (SLOTS),
      .MAX_FIRES (MAX_FIRES)
   ) timer_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_slot            (req_slot),
      .req_time_value      (req_time_value),
      .req_reload_interval (req_reload_interval),
      .req_user_tag        (req_user_tag),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_slot_id         (rsp_slot_id),
      .rsp_status          (rsp_status),
      .rsp_time_out        (rsp_time_out),
      .rsp_interval_out    (rsp_interval_out),
      .rsp_tag_out         (rsp_tag_out),
      .rsp_fired           (rsp_fired),
      .rsp_last            (rsp_last),
      .fail_count          (fail_count),
      .responses_owed      (responses_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offer one request. Change inputs only at the falling edge, optionally after
   // a random idle burst, then hold valid and payload until the rising edge that
   // accepts the request. Valid stays high on return so that a back-to-back
   // request never lowers and raises it in the same step.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_ID_W-1:0] sl,
                               input logic [TIME_IN_W-1:0] tv,
                               input logic [TIME_IN_W-1:0] iv,
                               input logic [TAG_W-1:0] ut);
      int gap;
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_op              <= op;
      req_slot            <= sl;
      req_time_value      <= tv;
      req_reload_interval <= iv;
      req_user_tag        <= ut;
      do @(posedge clock); while (!req_ready);
   endtask

   // Response side: alternate ready and stall bursts, take the one long hold
   // when asked, and stay ready for good once the quiet tail begins.
   initial begin : response_side
      int burst;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!no_idle && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            burst = $urandom_range(1, 14);
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            burst = no_idle ? 1 : $urandom_range(1, 30);
            repeat (burst - 1) @(negedge clock);
         end
      end
   end

   // Give up when neither channel completes a handshake for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      logic [TIME_IN_W-1:0] now_time;
      logic [TIME_IN_W-1:0] tv;
      logic [TIME_IN_W-1:0] iv;
      logic [OP_W-1:0]      op;
      int                   pick;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // empty table: next expiry reports nothing due
      send_request(OP_NEXT, '0, 32'd10, '0, '0);
      // free slot: info and cancel both report the slot as not active
      send_request(OP_INFO, 4'hF, '0, '0, '0);
      send_request(OP_CANCEL, 4'd3, '0, '0, '0);
      // unknown opcode with every field at its top value
      send_request(OP_TOP, '1, '1, '1, '1);
      // process at the top of time with nothing stored
      send_request(OP_PROCESS, '0, '1, '0, '0);
      // period-1 timer at time zero, then overrun the result limit
      send_request(OP_ADD, '0, '0, 32'd1, 16'hFFFF);
      send_request(OP_PROCESS, '0, 32'd70, '0, '0);
      // fill the table: paired deadlines tie, every third slot is one-shot,
      // periodic slots reload in big steps, the last one overflows on reload
      for (int k = 1; k < SLOTS; k++) begin
         if (k == SLOTS - 1)
            send_request(OP_ADD, '0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'h5A5A);
         else
            send_request(OP_ADD, SLOT_ID_W'(k), 32'd1000 + 32'(k / 2 * 10),
                         (k % 3 == 0) ? 32'd0 : (32'(k) << 27), TAG_W'(k * 16'h1111));
      end
      // table full
      send_request(OP_ADD, '0, 32'd5, 32'd5, 16'h1234);
      send_request(OP_INFO, 4'hF, '0, '0, '0);
      // next expiry ahead of the earliest deadline, then overdue
      send_request(OP_NEXT, '0, '0, '0, '0);
      send_request(OP_NEXT, '0, '1, '0, '0);
      // drop the period-1 timer and drain the rest across two process calls
      send_request(OP_CANCEL, 4'd0, '0, '0, '0);
      send_request(OP_PROCESS, '0, '1, '0, '0);
      send_request(OP_PROCESS, '0, '1, '0, '0);

      // ---- random part ----
      // Most requests follow a clock that only moves forward: adds land a
      // little ahead of it and process calls advance it. A few use raw values.
      now_time = 32'd0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == HOLD_AT) long_hold = 1'b1;
         if (n == DRAIN_AT) begin
            // pause the request side until every response is in
            @(negedge clock);
            req_valid <= 1'b0;
            wait (responses_owed == 0);
         end
         if (n == RANDOM_ITEMS / 2) now_time = 32'hFFFF_FF00;  // run up to the wrap
         if (n == RANDOM_ITEMS - QUIET_ITEMS) no_idle = 1'b1;

         tv   = $urandom;
         iv   = $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            op = OP_ADD;
            if ($urandom_range(0, 7) != 0) tv = now_time + $urandom_range(0, 120);
            case ($urandom_range(0, 4))
               0, 1:    iv = '0;
               2, 3:    iv = $urandom_range(1, 50);
               default: ;
            endcase
         end else if (pick < 55) begin
            op = OP_PROCESS;
            if ($urandom_range(0, 9) != 0) begin
               now_time = now_time + $urandom_range(0, 60);
               tv = now_time;
            end
         end else if (pick < 67) begin
            op = OP_NEXT;
            if ($urandom_range(0, 3) != 0) tv = now_time;
         end else if (pick < 79) begin
            op = OP_INFO;
         end else if (pick < 94) begin
            op = OP_CANCEL;
         end else begin
            op = OP_W'($urandom_range(int'(OP_INFO) + 1, int'(OP_TOP)));
         end
         send_request(op, SLOT_ID_W'($urandom), tv, iv, TAG_W'($urandom));
      end

      // release the request side, let every response arrive and settle
      @(negedge clock);
      req_valid <= 1'b0;
      wait (responses_owed == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
